// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, reset included.
`define BCB_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property outside reset.
`define BCB_ASSERT_ON(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/bcb_pkg.sv =====
`default_nettype none

package bcb_pkg;

   localparam int COORD_BITS_DEFAULT = 13;

   localparam int DIM_W   = 13;
   localparam int PITCH_W = 16;
   localparam int ADDR_W  = 32;
   localparam int BPP_W   = 16;
   localparam int COLOR_W = 32;
   localparam int BYTE_W  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 13'd1024;
   localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 13'd768;
   localparam logic [PITCH_W-1:0] PITCH_RST         = 16'd4096;
   localparam logic [BPP_W-1:0]   BPP_RST           = 16'd32;

   localparam logic [BPP_W-1:0]   BPP_24 = 16'd24;
   localparam logic [BPP_W-1:0]   BPP_32 = 16'd32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_PITCH_BYTES   = 3'd2,
      CSR_FRAME_BASE    = 3'd3,
      CSR_IMAGE_WIDTH   = 3'd4,
      CSR_IMAGE_HEIGHT  = 3'd5,
      CSR_BITS_PER_PIX  = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/bitmap_centered_blit.sv =====
// Channel  Ports                                    Direction  Moves
// req      req_valid/req_ready, req_source_byte     in         one pixel-data byte
// rsp      rsp_valid/rsp_ready, rsp_write_address,  out        one visible pixel write
//          rsp_pixel_colour
// csr      csr_wr_en, csr_index, csr_wdata          in         one register write
//
// One request per cycle unless rsp stalls; a pixel's write is registered in each stage below.
// Three register stages: byte gather and counters, centering and clip, address multiply-add.
// Synchronous active-high reset loads register defaults and clears gather state and stages.
// A stall on rsp fills the stages; req_ready drops only when every stage holds a pixel.
`default_nettype none

module bitmap_centered_blit
   import bcb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_source_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [ADDR_W-1:0]          rsp_write_address,
   output logic [COLOR_W-1:0]         rsp_pixel_colour,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW    = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 3;
   localparam int CMP_W = ((COORD_BITS + 1) > DIM_W) ? (COORD_BITS + 1) : DIM_W;
   localparam int PROD_W = DIM_W + PITCH_W;

   logic [DIM_W-1:0]   screen_width_ff, screen_width_in;
   logic [DIM_W-1:0]   screen_height_ff, screen_height_in;
   logic [PITCH_W-1:0] pitch_ff, pitch_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [DIM_W-1:0]   image_width_ff, image_width_in;
   logic [DIM_W-1:0]   image_height_ff, image_height_in;
   logic [BPP_W-1:0]   bpp_ff, bpp_in;

   logic [23:0]           gathered_ff, gathered_in;
   logic [1:0]            pos_ff, pos_in;
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;

   logic                  a_valid_ff, a_valid_in;
   logic [COLOR_W-1:0]    a_colour_ff, a_colour_in;
   logic [COORD_BITS-1:0] a_col_ff, a_col_in;
   logic [COORD_BITS-1:0] a_row_ff, a_row_in;

   logic                  b_valid_ff, b_valid_in;
   logic [COLOR_W-1:0]    b_colour_ff, b_colour_in;
   logic [DIM_W-1:0]      b_sx_ff, b_sx_in;
   logic [DIM_W-1:0]      b_sy_ff, b_sy_in;

   logic                  c_valid_ff, c_valid_in;
   logic [COLOR_W-1:0]    c_colour_ff, c_colour_in;
   logic [ADDR_W-1:0]     c_addr_ff, c_addr_in;

   logic                  c_ready, b_ready, a_ready, accept;
   logic                  is24, is32, active, complete;
   logic [COLOR_W-1:0]    colour;
   logic [31:0]           shifted;
   logic [COORD_BITS:0]   col_inc, row_inc;
   logic                  col_end, row_end;
   logic [SW-1:0]         diff_x, diff_y, start_x, start_y, sx, sy;
   logic                  visible;
   logic [PROD_W-1:0]     row_offset;

   assign c_ready = !c_valid_ff || rsp_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign req_ready = a_ready;
   assign accept = req_valid && a_ready;

   assign rsp_valid = c_valid_ff;
   assign rsp_write_address = c_addr_ff;
   assign rsp_pixel_colour = c_colour_ff;

   // Gather bytes, step the source counters and load the first stage.
   always_comb begin
      is24 = (bpp_ff == BPP_24);
      is32 = (bpp_ff == BPP_32);
      active = (is24 || is32) && (image_width_ff != '0) && (image_height_ff != '0);
      complete = is24 ? (pos_ff >= 2'd2) : (pos_ff == 2'd3);
      colour = is24 ? {8'h00, req_source_byte, gathered_ff[15:0]}
                    : {req_source_byte, gathered_ff};
      shifted = {24'h0, req_source_byte} << {pos_ff, 3'b000};

      col_inc = {1'b0, col_ff} + {{COORD_BITS{1'b0}}, 1'b1};
      row_inc = {1'b0, row_ff} + {{COORD_BITS{1'b0}}, 1'b1};
      col_end = CMP_W'(col_inc) >= CMP_W'(image_width_ff);
      row_end = CMP_W'(row_inc) >= CMP_W'(image_height_ff);

      gathered_in = gathered_ff;
      pos_in = pos_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept && active) begin
         if (complete) begin
            gathered_in = '0;
            pos_in = '0;
            if (col_end) begin
               col_in = '0;
               row_in = row_end ? '0 : row_inc[COORD_BITS-1:0];
            end else begin
               col_in = col_inc[COORD_BITS-1:0];
            end
         end else begin
            gathered_in = gathered_ff | shifted[23:0];
            pos_in = pos_ff + 2'd1;
         end
      end

      a_valid_in = a_valid_ff;
      a_colour_in = a_colour_ff;
      a_col_in = a_col_ff;
      a_row_in = a_row_ff;
      if (a_ready) begin
         a_valid_in = accept && active && complete;
         a_colour_in = colour;
         a_col_in = col_ff;
         a_row_in = row_ff;
      end
   end

   // Center, flip and clip.
   always_comb begin
      diff_x = SW'(screen_width_ff) - SW'(image_width_ff);
      diff_y = SW'(screen_height_ff) - SW'(image_height_ff);
      start_x = diff_x + {{(SW-1){1'b0}}, diff_x[SW-1]};
      start_x = {start_x[SW-1], start_x[SW-1:1]};
      start_y = diff_y + {{(SW-1){1'b0}}, diff_y[SW-1]};
      start_y = {start_y[SW-1], start_y[SW-1:1]};
      sx = start_x + SW'(a_col_ff);
      sy = start_y + SW'(image_height_ff) - {{(SW-1){1'b0}}, 1'b1} - SW'(a_row_ff);
      visible = !sx[SW-1] && (sx < SW'(screen_width_ff))
             && !sy[SW-1] && (sy < SW'(screen_height_ff));

      b_valid_in = b_valid_ff;
      b_colour_in = b_colour_ff;
      b_sx_in = b_sx_ff;
      b_sy_in = b_sy_ff;
      if (b_ready) begin
         b_valid_in = a_valid_ff && visible;
         b_colour_in = a_colour_ff;
         b_sx_in = sx[DIM_W-1:0];
         b_sy_in = sy[DIM_W-1:0];
      end
   end

   // Form the framebuffer address.
   always_comb begin
      row_offset = PROD_W'(b_sy_ff) * PROD_W'(pitch_ff);
      c_valid_in = c_valid_ff;
      c_colour_in = c_colour_ff;
      c_addr_in = c_addr_ff;
      if (c_ready) begin
         c_valid_in = b_valid_ff;
         c_colour_in = b_colour_ff;
         c_addr_in = base_ff + ADDR_W'(row_offset) + ADDR_W'({b_sx_ff, 2'b00});
      end
   end

   always_comb begin
      screen_width_in = screen_width_ff;
      screen_height_in = screen_height_ff;
      pitch_in = pitch_ff;
      base_in = base_ff;
      image_width_in = image_width_ff;
      image_height_in = image_height_ff;
      bpp_in = bpp_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in = csr_wdata[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata[DIM_W-1:0];
            CSR_PITCH_BYTES:   pitch_in = csr_wdata[PITCH_W-1:0];
            CSR_FRAME_BASE:    base_in = csr_wdata[ADDR_W-1:0];
            CSR_IMAGE_WIDTH:   image_width_in = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  image_height_in = csr_wdata[DIM_W-1:0];
            CSR_BITS_PER_PIX:  bpp_in = csr_wdata[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
         pitch_ff <= PITCH_RST;
         base_ff <= '0;
         image_width_ff <= '0;
         image_height_ff <= '0;
         bpp_ff <= BPP_RST;
         gathered_ff <= '0;
         pos_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         screen_width_ff <= screen_width_in;
         screen_height_ff <= screen_height_in;
         pitch_ff <= pitch_in;
         base_ff <= base_in;
         image_width_ff <= image_width_in;
         image_height_ff <= image_height_in;
         bpp_ff <= bpp_in;
         gathered_ff <= gathered_in;
         pos_ff <= pos_in;
         col_ff <= col_in;
         row_ff <= row_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
      a_colour_ff <= a_colour_in;
      a_col_ff <= a_col_in;
      a_row_ff <= a_row_in;
      b_colour_ff <= b_colour_in;
      b_sx_ff <= b_sx_in;
      b_sy_ff <= b_sy_in;
      c_colour_ff <= c_colour_in;
      c_addr_ff <= c_addr_in;
   end

endmodule

`default_nettype wire

// ===== rtl/bcb_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module bcb_checker
   import bcb_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [ADDR_W-1:0]  rsp_write_address,
   input wire logic [COLOR_W-1:0] rsp_pixel_colour
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   `BCB_ASSERT(a_rsp_clear_after_reset, clock, reset |=> !rsp_valid, "rsp_valid set after reset")
   `BCB_ASSERT(a_rsp_latency, clock, $fell(reset) |-> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid, "rsp earlier than pipeline depth")
   `BCB_ASSERT_ON(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped while stalled")
   `BCB_ASSERT_ON(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_write_address) && $stable(rsp_pixel_colour), "rsp payload changed while stalled")
   `BCB_ASSERT_ON(a_req_fire_known, clock, reset, req_fire |-> !$isunknown(req_ready), "req_ready unknown at accept")

endmodule

bind bitmap_centered_blit bcb_checker u_bcb_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench
   import bcb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_AFTER   = 40;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned RANDOM_BYTES = 1000;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [COLOR_W-1:0] colour;
   } pixel_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_source_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ADDR_W-1:0]     rsp_write_address;
   logic [COLOR_W-1:0]    rsp_pixel_colour;
   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_SCREEN_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // blitter configuration and gather state as the block should hold them
   logic [DIM_W-1:0]   blit_screen_w = SCREEN_WIDTH_RST;
   logic [DIM_W-1:0]   blit_screen_h = SCREEN_HEIGHT_RST;
   logic [PITCH_W-1:0] blit_pitch    = PITCH_RST;
   logic [ADDR_W-1:0]  blit_base     = '0;
   logic [DIM_W-1:0]   blit_image_w  = '0;
   logic [DIM_W-1:0]   blit_image_h  = '0;
   logic [BPP_W-1:0]   blit_bpp      = BPP_RST;
   logic [23:0]        gathered_bgr  = '0;
   logic [1:0]         byte_slot     = '0;
   logic [COORD_BITS_DEFAULT-1:0] src_col = '0;
   logic [COORD_BITS_DEFAULT-1:0] src_row = '0;

   pixel_write_type   expected_writes[$];
   logic [BYTE_W-1:0] pending_bytes[$];
   logic              idle_enable = 1'b0;
   int unsigned       error_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       send_gap = 0;
   int unsigned       stall_left = 0;
   int unsigned       hold_left = 0;
   int unsigned       writes_taken = 0;
   logic              hold_done = 1'b0;

   bitmap_centered_blit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_byte   (req_source_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_colour  (rsp_pixel_colour),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [BYTE_W-1:0] random_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int unsigned random_image_dim();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return 8191;
         2: return $urandom_range(11, 8191);
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   function automatic void predict_blit_byte(input logic [BYTE_W-1:0] b);
      logic [COLOR_W-1:0] colour;
      int startx, starty, sx, sy;
      pixel_write_type w;
      if (blit_bpp != BPP_24 && blit_bpp != BPP_32) return;
      if (blit_image_w == '0 || blit_image_h == '0) return;
      if (blit_bpp == BPP_24 && byte_slot >= 2'd2) begin
         colour = {8'h00, b, gathered_bgr[15:0]};
      end else if (blit_bpp == BPP_32 && byte_slot == 2'd3) begin
         colour = {b, gathered_bgr};
      end else begin
         gathered_bgr = gathered_bgr | (24'(b) << (8 * byte_slot));
         byte_slot = byte_slot + 2'd1;
         return;
      end
      gathered_bgr = '0;
      byte_slot = '0;
      startx = (int'(blit_screen_w) - int'(blit_image_w)) / 2;
      starty = (int'(blit_screen_h) - int'(blit_image_h)) / 2;
      sx = startx + int'(src_col);
      sy = starty + int'(blit_image_h) - 1 - int'(src_row);
      // advance, wrapping at the end of the row and of the image
      if (int'(src_col) + 1 >= int'(blit_image_w)) begin
         src_col = '0;
         if (int'(src_row) + 1 >= int'(blit_image_h)) src_row = '0;
         else src_row = src_row + 1'b1;
      end else begin
         src_col = src_col + 1'b1;
      end
      if (sx < 0 || sx >= int'(blit_screen_w) || sy < 0 || sy >= int'(blit_screen_h)) return;
      w.address = blit_base + ADDR_W'(sy) * ADDR_W'(blit_pitch) + ADDR_W'(sx) * 32'd4;
      w.colour = colour;
      expected_writes.push_back(w);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      int unsigned width;
      logic [CSR_DATA_W-1:0] junk;
      case (idx)
         CSR_PITCH_BYTES, CSR_BITS_PER_PIX: width = 16;
         CSR_FRAME_BASE: width = 32;
         default: width = DIM_W;
      endcase
      junk = $urandom();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (width == 32) ? value
                                 : ((junk << width) | (value & ((32'd1 << width) - 32'd1)));
      case (idx)
         CSR_SCREEN_WIDTH:  blit_screen_w = value[DIM_W-1:0];
         CSR_SCREEN_HEIGHT: blit_screen_h = value[DIM_W-1:0];
         CSR_PITCH_BYTES:   blit_pitch    = value[PITCH_W-1:0];
         CSR_FRAME_BASE:    blit_base     = value;
         CSR_IMAGE_WIDTH:   blit_image_w  = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT:  blit_image_h  = value[DIM_W-1:0];
         CSR_BITS_PER_PIX:  blit_bpp      = value[BPP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [31:0] sw, input logic [31:0] sh,
                            input logic [31:0] pitch, input logic [31:0] base,
                            input logic [31:0] iw, input logic [31:0] ih,
                            input logic [31:0] bpp);
      csr_write(CSR_SCREEN_WIDTH, sw);
      csr_write(CSR_SCREEN_HEIGHT, sh);
      csr_write(CSR_PITCH_BYTES, pitch);
      csr_write(CSR_FRAME_BASE, base);
      csr_write(CSR_IMAGE_WIDTH, iw);
      csr_write(CSR_IMAGE_HEIGHT, ih);
      csr_write(CSR_BITS_PER_PIX, bpp);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic open_batch();
      @(negedge clock);
      idle_enable = ($urandom_range(0, 3) != 0);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_writes.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_bytes.size() != 0) begin
            req_valid <= 1'b1;
            req_source_byte <= pending_bytes.pop_front();
            send_gap <= (idle_enable && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         writes_taken <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) writes_taken <= writes_taken + 1;
         // hold off once long enough for the pipeline to back up into req
         if (!hold_done && writes_taken == HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            stall_left <= pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_writes
      pixel_write_type want;
      if (!reset) begin
         if (req_valid && req_ready) predict_blit_byte(req_source_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               report_mismatch("unexpected write", rsp_write_address, '0);
            end else begin
               want = expected_writes.pop_front();
               if (rsp_write_address !== want.address)
                  report_mismatch("write_address", rsp_write_address, want.address);
               if (rsp_pixel_colour !== want.colour)
                  report_mismatch("pixel_colour", rsp_pixel_colour, want.colour);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int unsigned counted, iw, ih, sw, sh, n, bpx;
      logic [31:0] bpp, pitch, base;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty image right after reset: drop everything
      open_batch();
      pending_bytes = {8'h00, 8'hFF};
      drain();

      // unsupported format
      configure(1, 1, 32'h0010, 32'hFFFF_FFFC, 2, 1, 16);
      open_batch();
      pending_bytes = {8'hFF, 8'h00};
      drain();

      // image wider than screen: offset truncates to zero, second pixel clipped
      configure(1, 1, 32'hFFFF, 32'hFFFF_FFFF, 2, 1, BPP_32);
      open_batch();
      pending_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
      drain();

      // switch to 24 bpp with three and with two bytes gathered
      open_batch();
      pending_bytes = {8'h12, 8'h34, 8'h56};
      drain();
      configure(1, 1, 32'hFFFF, 32'hFFFF_FFFF, 2, 1, BPP_24);
      open_batch();
      pending_bytes = {8'h78};
      drain();
      configure(1, 1, 32'hFFFF, 32'hFFFF_FFFF, 2, 1, BPP_32);
      open_batch();
      pending_bytes = {8'h9A, 8'hBC};
      drain();
      configure(1, 1, 32'hFFFF, 32'hFFFF_FFFF, 2, 1, BPP_24);
      open_batch();
      pending_bytes = {8'hDE};
      drain();

      // zero-size screen clips everything
      configure(0, 0, 0, 0, 2, 1, BPP_24);
      open_batch();
      pending_bytes = {8'h01, 8'h80, 8'h7F};
      drain();

      // fully visible image with the sender never idle
      configure(32, 32, 128, $urandom(), 8, 16, BPP_32);
      open_batch();
      idle_enable = 1'b0;
      repeat (512) pending_bytes.push_back(random_byte());
      drain();
      counted = 512;

      while (counted < RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            0: bpp = $urandom_range(0, 65535);
            1, 2, 3, 4: bpp = BPP_24;
            default: bpp = BPP_32;
         endcase
         iw = random_image_dim();
         ih = random_image_dim();
         case ($urandom_range(0, 9))
            0: sw = 0;
            1: sw = 8191;
            2: sw = $urandom_range(0, 8191);
            default: sw = $urandom_range(0, 16);
         endcase
         case ($urandom_range(0, 9))
            0: sh = 0;
            1: sh = 8191;
            2: sh = $urandom_range(0, 8191);
            default: sh = $urandom_range(0, 16);
         endcase
         case ($urandom_range(0, 9))
            0: pitch = 0;
            1: pitch = 32'hFFFF;
            default: pitch = $urandom_range(0, 65535);
         endcase
         case ($urandom_range(0, 9))
            0: base = 0;
            1: base = 32'hFFFF_FFFF;
            default: base = $urandom();
         endcase
         configure(sw, sh, pitch, base, iw, ih, bpp);
         bpx = (bpp == BPP_24) ? 3 : 4;
         if (iw * ih != 0 && iw * ih <= 100 && $urandom_range(0, 3) != 0)
            n = iw * ih * bpx * $urandom_range(1, 2);
         else
            n = $urandom_range(1, 40);
         open_batch();
         repeat (n) pending_bytes.push_back(random_byte());
         drain();
         if ((bpp == BPP_24 || bpp == BPP_32) && iw != 0 && ih != 0) counted += n;
      end

      drain();
      if (error_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/bcb_pkg.sv
rtl/bitmap_centered_blit.sv
rtl/bcb_checker.sv
dv/testbench.sv
